>>> rtl/jsar_pkg.sv
// ----------------------------------------------------------------------------
// jsar_pkg: shared types and constants for the joystick scroll auto-repeat
// Word layouts, event kinds, register indexes and the state record.
// ----------------------------------------------------------------------------
package jsar_pkg;

  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned THR_W   = 15;
  localparam int unsigned CODE_W  = 5;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IN_W    = 120;  // 115 field bits padded to bytes
  localparam int unsigned OUT_W   = 56;   // 53 field bits padded to bytes

  // event kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [IDX_W-1:0] REG_FIRST     = 3'd1;
  localparam logic [IDX_W-1:0] REG_NORMAL    = 3'd2;
  localparam logic [IDX_W-1:0] REG_STEP      = 3'd3;
  localparam logic [IDX_W-1:0] REG_FLOOR     = 3'd4;

  // register reset values
  localparam logic [THR_W-1:0] THRESHOLD_RST = 15'd14746;  // 0.45 in Q0.15
  localparam logic [MS_W-1:0]  FIRST_RST     = 16'd250;
  localparam logic [MS_W-1:0]  NORMAL_RST    = 16'd50;
  localparam logic [MS_W-1:0]  STEP_RST      = 16'd5;
  localparam logic [MS_W-1:0]  FLOOR_RST     = 16'd25;

  // direction bits and click code
  localparam logic [CODE_W-1:0] CODE_RIGHT = 5'd1;
  localparam logic [CODE_W-1:0] CODE_LEFT  = 5'd2;
  localparam logic [CODE_W-1:0] CODE_UP    = 5'd4;
  localparam logic [CODE_W-1:0] CODE_DOWN  = 5'd8;
  localparam logic [CODE_W-1:0] CODE_CLICK = 5'd16;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [MS_W-1:0]  first_delay;
    logic [MS_W-1:0]  normal_delay;
    logic [MS_W-1:0]  delay_step;
    logic [MS_W-1:0]  floor_delay;
  } cfg_t;

  typedef struct packed {
    logic            armed;
    logic            has_scrolled;
    logic            was_pressed;
    logic [MS_W-1:0] time_left;
    logic [MS_W-1:0] repeat_interval;
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [MS_W-1:0]   elapsed_ms;
    logic [AXIS_W-1:0] horiz_pos;
    logic              horiz_valid;
    logic [AXIS_W-1:0] vert_pos;
    logic              vert_valid;
    logic [AXIS_W-1:0] press_level;
    logic              press_valid;
  } item_t;

endpackage

>>> rtl/jsar_step.sv
// ----------------------------------------------------------------------------
// jsar_step: per-word decision logic
// Next state and optional result code for one event, purely combinational.
// ----------------------------------------------------------------------------
module jsar_step (
  input  jsar_pkg::cfg_t                   cfg,
  input  jsar_pkg::state_t                 cur,
  input  jsar_pkg::item_t                  item,
  output jsar_pkg::state_t                 nxt,
  output logic                             emit,
  output logic [jsar_pkg::CODE_W-1:0]      code
);

  logic signed [jsar_pkg::AXIS_W:0] thr_pos;
  logic signed [jsar_pkg::AXIS_W:0] thr_neg;
  logic signed [jsar_pkg::AXIS_W:0] h;
  logic signed [jsar_pkg::AXIS_W:0] v;
  logic [jsar_pkg::CODE_W-1:0]      dir;
  logic                             pressed;
  logic [jsar_pkg::MS_W-1:0]        shrunk;

  assign thr_pos = $signed({2'b00, cfg.threshold});
  assign thr_neg = -thr_pos;
  // absent axis sample reads as centered
  assign h = item.horiz_valid ? $signed({item.horiz_pos[jsar_pkg::AXIS_W-1], item.horiz_pos})
                              : '0;
  assign v = item.vert_valid ? $signed({item.vert_pos[jsar_pkg::AXIS_W-1], item.vert_pos})
                             : '0;

  always_comb begin
    dir = '0;
    if (h > thr_pos) dir = dir | jsar_pkg::CODE_RIGHT;
    else if (h < thr_neg) dir = dir | jsar_pkg::CODE_LEFT;
    if (v > thr_pos) dir = dir | jsar_pkg::CODE_UP;
    else if (v < thr_neg) dir = dir | jsar_pkg::CODE_DOWN;
  end

  assign pressed = item.press_valid && !item.press_level[jsar_pkg::AXIS_W-1]
                   && (item.press_level != '0);

  // interval shrink: first -> normal, then step down while above the floor delay, clamped at zero
  always_comb begin
    shrunk = cur.repeat_interval;
    if (cur.repeat_interval > cfg.floor_delay) begin
      if (cur.repeat_interval == cfg.first_delay) shrunk = cfg.normal_delay;
      else if (cur.repeat_interval > cfg.delay_step)
        shrunk = cur.repeat_interval - cfg.delay_step;
      else shrunk = '0;
    end
  end

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    code = dir;
    case (item.kind)
      jsar_pkg::KIND_START: begin
        if (!cur.armed) begin
          nxt.armed           = 1'b1;
          nxt.has_scrolled    = 1'b0;
          nxt.was_pressed     = 1'b0;
          nxt.time_left       = '0;
          nxt.repeat_interval = cfg.first_delay;
        end
      end
      jsar_pkg::KIND_END: begin
        if (cur.armed) begin
          nxt.armed = 1'b0;
          emit      = !cur.has_scrolled && cur.was_pressed;
          code      = jsar_pkg::CODE_CLICK;
        end
      end
      jsar_pkg::KIND_TICK: begin
        if (cur.armed) begin
          if (pressed) nxt.was_pressed = 1'b1;
          if (dir == '0) begin
            nxt.time_left       = '0;
            nxt.repeat_interval = cfg.first_delay;
          end else begin
            nxt.has_scrolled = 1'b1;
            if (cur.time_left == '0) begin
              nxt.time_left = cur.repeat_interval;
              emit          = 1'b1;
            end else if (cur.time_left <= item.elapsed_ms) begin
              nxt.repeat_interval = shrunk;
              nxt.time_left       = shrunk;
              emit                = 1'b1;
            end else begin
              nxt.time_left = cur.time_left - item.elapsed_ms;
            end
          end
        end
      end
      default: begin
        // unused kind: no effect
      end
    endcase
  end

endmodule

>>> rtl/joystick_scroll_auto_repeat.sv
// ----------------------------------------------------------------------------
// joystick_scroll_auto_repeat: stick to scroll code with accelerating repeat
// Input register, one pass of decision logic, output register.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the result stream is not stalled; the only loop is the
//   state update through the combinational jsar_step back into the state register.
// Reset (rst, synchronous): disarmed, countdown zero, interval at the first
//   delay, registers at their defaults, both pipeline registers empty.
module joystick_scroll_auto_repeat (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [jsar_pkg::IDX_W-1:0]    cfg_index,
  input  logic [jsar_pkg::CFG_W-1:0]    cfg_data,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tdata, low bit up: elapsed_ms[15:0], time_stamp[63:16], horiz_pos[79:64],
  //   horiz_valid[80], vert_pos[96:81], vert_valid[97], press_level[113:98],
  //   press_valid[114], zero pad[119:115]
  input  logic [jsar_pkg::IN_W-1:0]     s_tdata,
  // tuser: kind[1:0]
  input  logic [jsar_pkg::KIND_W-1:0]   s_tuser,
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tdata, low bit up: scroll_code[4:0], event_time[52:5], zero pad[55:53]
  output logic [jsar_pkg::OUT_W-1:0]    m_tdata
);

  // configuration registers
  jsar_pkg::cfg_t   cfg;

  // architectural state
  jsar_pkg::state_t st;
  jsar_pkg::state_t st_next;

  // input register
  logic                         in_vld;
  jsar_pkg::item_t              in_item;
  logic [jsar_pkg::TIME_W-1:0]  in_time;

  // step results
  logic                         emit;
  logic [jsar_pkg::CODE_W-1:0]  code;

  // handshake control
  logic proc;       // word in the input register is evaluated this cycle
  logic out_free;   // output register can take a result this cycle

  assign out_free = !m_tvalid || m_tready;
  assign proc     = in_vld && out_free;
  assign s_tready = !in_vld || proc;

  // ---- configuration ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold    <= jsar_pkg::THRESHOLD_RST;
      cfg.first_delay  <= jsar_pkg::FIRST_RST;
      cfg.normal_delay <= jsar_pkg::NORMAL_RST;
      cfg.delay_step   <= jsar_pkg::STEP_RST;
      cfg.floor_delay  <= jsar_pkg::FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jsar_pkg::REG_THRESHOLD: cfg.threshold    <= cfg_data[jsar_pkg::THR_W-1:0];
        jsar_pkg::REG_FIRST:     cfg.first_delay  <= cfg_data;
        jsar_pkg::REG_NORMAL:    cfg.normal_delay <= cfg_data;
        jsar_pkg::REG_STEP:      cfg.delay_step   <= cfg_data;
        jsar_pkg::REG_FLOOR:     cfg.floor_delay  <= cfg_data;
        default: begin
          // indexes past the register list are dropped
        end
      endcase
    end
  end

  // ---- input register -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) in_vld <= 1'b0;
    else if (s_tready) in_vld <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.kind        <= s_tuser;
      in_item.elapsed_ms  <= s_tdata[15:0];
      in_time             <= s_tdata[63:16];
      in_item.horiz_pos   <= s_tdata[79:64];
      in_item.horiz_valid <= s_tdata[80];
      in_item.vert_pos    <= s_tdata[96:81];
      in_item.vert_valid  <= s_tdata[97];
      in_item.press_level <= s_tdata[113:98];
      in_item.press_valid <= s_tdata[114];
    end
  end

  // ---- decision logic -----------------------------------------------------
  jsar_step u_step (
    .cfg  (cfg),
    .cur  (st),
    .item (in_item),
    .nxt  (st_next),
    .emit (emit),
    .code (code)
  );

  // state advances only when the word is evaluated
  always_ff @(posedge clk) begin
    if (rst) begin
      st.armed           <= 1'b0;
      st.has_scrolled    <= 1'b0;
      st.was_pressed     <= 1'b0;
      st.time_left       <= '0;
      st.repeat_interval <= jsar_pkg::FIRST_RST;
    end else if (proc) begin
      st <= st_next;
    end
  end

  // ---- output register ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_free) m_tvalid <= proc && emit;
  end

  always_ff @(posedge clk) begin
    if (proc && emit) m_tdata <= {3'b000, in_time, code};
  end

  // ---- assertions ---------------------------------------------------------
  // a result always carries a direction or the click
  a_code_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[jsar_pkg::CODE_W-1:0] != '0))
    else $error("result with empty scroll code");

  // a new result only appears after an evaluated word
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid)) |-> $past(proc))
    else $error("result without an evaluated word");

  // an evaluated end event always leaves the block disarmed
  a_end_disarms: assert property (@(posedge clk) disable iff (rst)
    (proc && in_item.kind == jsar_pkg::KIND_END) |=> !st.armed)
    else $error("still armed after end event");

  // a click is only produced by an end event
  a_click_on_end: assert property (@(posedge clk) disable iff (rst)
    (proc && emit && code == jsar_pkg::CODE_CLICK) |-> (in_item.kind == jsar_pkg::KIND_END))
    else $error("click outside end event");

endmodule
